### hw/rtl/kfs_pkg.sv
// Shared types and constants for the keyframe segment search block.
// Depends on nothing; every other file of the block but kfs_ram imports it.
package kfs_pkg;

  localparam int unsigned MAX_KEYS = 256;
  localparam int unsigned KEY_AW   = $clog2(MAX_KEYS);
  localparam int unsigned CNT_W    = KEY_AW + 1;
  localparam int unsigned TIME_W   = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_KEYS);
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(2);

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PROBE,
    ST_SEG_RD,
    ST_SEG_CHK,
    ST_LAST_LD,
    ST_LEN,
    ST_OUT
  } kfs_state_e;

  typedef struct packed {
    logic signed [TIME_W-1:0] a;
    logic signed [TIME_W-1:0] b;
  } kfs_alu_op_t;

  typedef struct packed {
    logic signed [TIME_W-1:0] diff;
    logic                     neg;
  } kfs_alu_res_t;

endpackage

### hw/rtl/kfs_req_if.sv
// Request channel interface: key loads and segment queries.
// Depends on kfs_pkg.
interface kfs_req_if
  import kfs_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [KEY_AW-1:0]        key_slot;
  logic signed [TIME_W-1:0] time_value;
  logic                     back_step_at_key;

  modport source (output valid, req_type, key_slot, time_value, back_step_at_key,
                  input ready);
  modport sink (input valid, req_type, key_slot, time_value, back_step_at_key,
                output ready);
endinterface

### hw/rtl/kfs_res_if.sv
// Result channel interface: segment index, offset and length.
// Depends on kfs_pkg.
interface kfs_res_if
  import kfs_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [KEY_AW-1:0]        segment_index;
  logic signed [TIME_W-1:0] time_into_segment;
  logic signed [TIME_W-1:0] segment_length;

  modport source (output valid, segment_index, time_into_segment, segment_length,
                  input ready);
  modport sink (input valid, segment_index, time_into_segment, segment_length,
                output ready);
endinterface

### hw/rtl/kfs_cfg_if.sv
// Configuration write channel interface carrying the key count register.
// Depends on kfs_pkg.
interface kfs_cfg_if
  import kfs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] key_count;

  modport source (output valid, key_count, input ready);
  modport sink (input valid, key_count, output ready);
endinterface

### hw/rtl/keyframe_segment_search.sv
// Top level of the keyframe segment search: key count register, time table,
// sequencer and shared subtract unit. Depends on kfs_pkg, the interfaces and submodules.
//
//   Port    Direction  Transaction
//   req_i   in         key load or segment query
//   res_o   out        segment index, offset into segment, segment length
//   cfg_i   in         key count register write
//
// A load completes in the cycle it is accepted and the block is ready again at once.
// A query runs a setup step, table probes (at most 8 for 256 keys), a segment read and
// check, a length step and the output; a back step adds one more segment read and check,
// after a last-key load at segment 0. Probes use the table's single registered read port.
// The table is not cleared at reset; reset returns the key count to 2 and the
// sequencer to idle. The block stays busy while a result waits on res_o.ready.
module keyframe_segment_search
  import kfs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  kfs_req_if.sink   req_i,
  kfs_res_if.source res_o,
  kfs_cfg_if.sink   cfg_i
);

  logic [CNT_W-1:0]  key_count_q;
  logic              ram_we;
  logic [KEY_AW-1:0] ram_waddr, ram_raddr;
  logic [TIME_W-1:0] ram_wdata, ram_rdata;
  kfs_alu_op_t       alu_op;
  kfs_alu_res_t      alu_res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= CNT_MIN;
    end else if (cfg_i.valid && cfg_i.ready) begin
      key_count_q <= cfg_i.key_count;
    end
  end

  kfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .res_o       (res_o),
    .key_count_i (key_count_q),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .alu_op_o    (alu_op),
    .alu_res_i   (alu_res)
  );

  kfs_alu u_alu (
    .op_i  (alu_op),
    .res_o (alu_res)
  );

  kfs_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_KEYS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

### hw/rtl/kfs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module kfs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/kfs_alu.sv
// Shared subtract unit: saturated signed difference a - b and its raw sign.
// Depends on kfs_pkg.
module kfs_alu
  import kfs_pkg::*;
(
  input  kfs_alu_op_t  op_i,
  output kfs_alu_res_t res_o
);

  logic signed [TIME_W:0] wide;

  always_comb begin
    wide = {op_i.a[TIME_W-1], op_i.a} - {op_i.b[TIME_W-1], op_i.b};
    res_o.neg = wide[TIME_W];
    if (wide[TIME_W] != wide[TIME_W-1]) begin
      res_o.diff = wide[TIME_W] ? {1'b1, {(TIME_W-1){1'b0}}} : {1'b0, {(TIME_W-1){1'b1}}};
    end else begin
      res_o.diff = wide[TIME_W-1:0];
    end
  end

endmodule

### hw/rtl/kfs_ctrl.sv
// Search sequencer: runs the binary search, back step and both differences
// through the shared subtract unit. Depends on kfs_pkg and the channel interfaces.
module kfs_ctrl
  import kfs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  kfs_req_if.sink             req_i,
  kfs_res_if.source           res_o,
  input  logic [CNT_W-1:0]    key_count_i,
  output logic                ram_we_o,
  output logic [KEY_AW-1:0]   ram_waddr_o,
  output logic [TIME_W-1:0]   ram_wdata_o,
  output logic [KEY_AW-1:0]   ram_raddr_o,
  input  logic [TIME_W-1:0]   ram_rdata_i,
  output kfs_alu_op_t         alu_op_o,
  input  kfs_alu_res_t        alu_res_i
);

  kfs_state_e state_q, state_d;

  logic [CNT_W-1:0]         first_q, first_d, last_q, last_d, cnt_q, cnt_d;
  logic [KEY_AW-1:0]        mid_q, mid_d, seg_q, seg_d;
  logic signed [TIME_W-1:0] t_q, t_d, start_q, start_d, off_q, off_d, len_q, len_d;
  logic                     back_q, back_d;

  logic [CNT_W-1:0]  cnt_in, nfirst, nlast, clamped;
  logic [CNT_W:0]    nsum, isum;
  logic              accept, query_go, done, hit;
  logic signed [TIME_W-1:0] rkey;

  assign rkey     = ram_rdata_i;
  assign accept   = req_i.valid && req_i.ready;
  assign cnt_in   = (key_count_i > CNT_MAX) ? CNT_MAX : key_count_i;
  assign query_go = accept && (req_i.req_type == REQ_QUERY) && (cnt_in >= CNT_MIN);

  assign nfirst  = !alu_res_i.neg ? ({1'b0, mid_q} + CNT_W'(1)) : first_q;
  assign nlast   = !alu_res_i.neg ? last_q : {1'b0, mid_q};
  assign nsum    = {1'b0, nfirst} + {1'b0, nlast};
  assign isum    = {1'b0, first_q} + {1'b0, last_q};
  assign done    = (nfirst == nlast);
  assign clamped = (nfirst >= cnt_q) ? (cnt_q - CNT_W'(1)) : nfirst;
  assign hit     = back_q && (alu_res_i.diff == '0) && !alu_res_i.neg;

  assign ram_we_o    = accept && (req_i.req_type == REQ_LOAD);
  assign ram_waddr_o = req_i.key_slot;
  assign ram_wdata_o = req_i.time_value;

  assign res_o.segment_index     = seg_q;
  assign res_o.time_into_segment = off_q;
  assign res_o.segment_length    = len_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (query_go) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: state_d = ST_PROBE;
      ST_PROBE: begin
        if (done) begin
          state_d = ST_SEG_RD;
        end
      end
      ST_SEG_RD: state_d = ST_SEG_CHK;
      ST_SEG_CHK: begin
        if (hit) begin
          state_d = (seg_q == '0) ? ST_LAST_LD : ST_SEG_RD;
        end else begin
          state_d = ST_LEN;
        end
      end
      ST_LAST_LD: state_d = ST_SEG_RD;
      ST_LEN:     state_d = ST_OUT;
      ST_OUT: begin
        if (res_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    first_d     = first_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    mid_d       = mid_q;
    seg_d       = seg_q;
    t_d         = t_q;
    start_d     = start_q;
    off_d       = off_q;
    len_d       = len_q;
    back_d      = back_q;
    req_i.ready = 1'b0;
    res_o.valid = 1'b0;
    ram_raddr_o = mid_q;
    alu_op_o.a  = t_q;
    alu_op_o.b  = rkey;
    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (query_go) begin
          first_d = CNT_W'(1);
          last_d  = cnt_in;
          cnt_d   = cnt_in;
          t_d     = req_i.time_value;
          back_d  = req_i.back_step_at_key;
        end
      end
      ST_SEARCH: begin
        mid_d       = isum[KEY_AW:1];
        ram_raddr_o = isum[KEY_AW:1];
      end
      ST_PROBE: begin
        first_d     = nfirst;
        last_d      = nlast;
        mid_d       = nsum[KEY_AW:1];
        ram_raddr_o = nsum[KEY_AW:1];
        if (done) begin
          seg_d = KEY_AW'(clamped - CNT_W'(1));
        end
      end
      ST_SEG_RD: begin
        ram_raddr_o = seg_q;
      end
      ST_SEG_CHK: begin
        ram_raddr_o = seg_q + KEY_AW'(1);
        if (hit) begin
          back_d = 1'b0;
          if (seg_q == '0) begin
            seg_d       = KEY_AW'(cnt_q - CNT_W'(2));
            ram_raddr_o = KEY_AW'(cnt_q - CNT_W'(1));
          end else begin
            seg_d = seg_q - KEY_AW'(1);
          end
        end else begin
          start_d = rkey;
          off_d   = alu_res_i.diff;
        end
      end
      ST_LAST_LD: begin
        t_d = rkey;
      end
      ST_LEN: begin
        alu_op_o.a = rkey;
        alu_op_o.b = start_q;
        len_d      = alu_res_i.diff;
      end
      ST_OUT: begin
        res_o.valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      back_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      back_q  <= back_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    last_q  <= last_d;
    cnt_q   <= cnt_d;
    mid_q   <= mid_d;
    seg_q   <= seg_d;
    t_q     <= t_d;
    start_q <= start_d;
    off_q   <= off_d;
    len_q   <= len_d;
  end

endmodule
